// File: design/lrpt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lrpt_pkg: shared definitions for the light radius pixel tint unit
// Widths, register indexes, zone codes and a helper function.
// ----------------------------------------------------------------------------
package lrpt_pkg;

  // Coordinate bits that take part in the distance.
  localparam int COORD_BITS = 10;

  localparam int CENTRE_W = 12;
  localparam int RADIUS_W = 11;
  localparam int GAIN_W   = 10;
  localparam int PIX_W    = 24;
  localparam int CH_W     = 8;

  // Signed difference x - centre and its magnitude.
  localparam int DIFF_W = ((COORD_BITS + 1 > CENTRE_W) ? COORD_BITS + 1 : CENTRE_W) + 1;
  localparam int ABS_W  = DIFF_W - 1;
  localparam int SQ_W   = 2 * ABS_W;
  localparam int SQ5_W  = SQ_W + 3;
  localparam int DIST_W = SQ_W + 2;
  localparam int RSQ_W  = 2 * RADIUS_W;

  // Warm tint products and the reciprocal used for the divide by 20.
  localparam int WARM_W      = 13;
  localparam int WARM_GREEN  = 21;
  localparam int WARM_BLUE   = 19;
  localparam int RECIP_W     = 12;
  localparam int RECIP20     = 3277;
  localparam int RECIP_SHIFT = 16;
  localparam int RPROD_W     = WARM_W + RECIP_W;
  localparam int QUOT_W      = 9;
  localparam int GPROD_W     = CH_W + GAIN_W;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 12;
  localparam logic [CFG_IDX_W-1:0] REG_CENTRE_X     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTRE_Y     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_RADIUS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OUTER_RADIUS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_RED     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_GREEN   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_BLUE    = 3'd6;

  localparam logic [GAIN_W-1:0] GAIN_UNITY = 10'd256;

  typedef enum logic [1:0] {
    ZONE_WARM   = 2'd0,
    ZONE_DITHER = 2'd1,
    ZONE_GAIN   = 2'd2
  } zone_e;

  // Channel products formed ahead of the divide and the saturation.
  typedef struct packed {
    logic [WARM_W-1:0]  warm_g;
    logic [WARM_W-1:0]  warm_b;
    logic [GPROD_W-1:0] gain_r;
    logic [GPROD_W-1:0] gain_g;
    logic [GPROD_W-1:0] gain_b;
  } prod_t;

  function automatic logic [CH_W-1:0] sat8(input logic [GAIN_W-1:0] v);
    sat8 = (v > GAIN_W'(255)) ? CH_W'(255) : v[CH_W-1:0];
  endfunction

endpackage
`default_nettype wire

// File: design/lrpt_chan_prod.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lrpt_chan_prod: per-channel products
// Forms the warm tint numerators and the three gain products of one pixel.
// ----------------------------------------------------------------------------
module lrpt_chan_prod (
  input  wire logic [lrpt_pkg::PIX_W-1:0]  pixel_i,
  input  wire logic [lrpt_pkg::GAIN_W-1:0] gain_red_i,
  input  wire logic [lrpt_pkg::GAIN_W-1:0] gain_green_i,
  input  wire logic [lrpt_pkg::GAIN_W-1:0] gain_blue_i,
  output lrpt_pkg::prod_t                  prod_o
);

  logic [lrpt_pkg::CH_W-1:0] red, green, blue;

  assign red   = pixel_i[23:16];
  assign green = pixel_i[15:8];
  assign blue  = pixel_i[7:0];

  assign prod_o.warm_g = lrpt_pkg::WARM_W'(green) * lrpt_pkg::WARM_W'(lrpt_pkg::WARM_GREEN);
  assign prod_o.warm_b = lrpt_pkg::WARM_W'(blue) * lrpt_pkg::WARM_W'(lrpt_pkg::WARM_BLUE);
  assign prod_o.gain_r = lrpt_pkg::GPROD_W'(red) * lrpt_pkg::GPROD_W'(gain_red_i);
  assign prod_o.gain_g = lrpt_pkg::GPROD_W'(green) * lrpt_pkg::GPROD_W'(gain_green_i);
  assign prod_o.gain_b = lrpt_pkg::GPROD_W'(blue) * lrpt_pkg::GPROD_W'(gain_blue_i);

endmodule
`default_nettype wire

// File: design/light_radius_pixel_tint_unit.sv
`default_nettype none
// Throughput: one item per cycle while the output is not stalled; the five register stages each hold one item.
// The stages follow the distance path: difference, square, sum, compare, select.
// Reset clears all valid bits and loads the register reset values (gains at unity).
// A stage accepts whenever it is empty or its successor moves, so bubbles collapse.
// ----------------------------------------------------------------------------
// light_radius_pixel_tint_unit: radial light tint of a pixel stream
// Classifies each pixel by its elliptical distance from a light centre and
// applies a warm tint, a dithered pass-through or a per-channel gain.
// ----------------------------------------------------------------------------
module light_radius_pixel_tint_unit (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // configuration port
  input  wire logic                                cfg_we_i,
  input  wire logic [lrpt_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire logic [lrpt_pkg::CFG_DAT_W-1:0]      cfg_data_i,
  // input channel
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic [lrpt_pkg::PIX_W-1:0]          pixel_in_i,
  input  wire logic [lrpt_pkg::COORD_BITS-1:0]     pixel_x_i,
  input  wire logic [lrpt_pkg::COORD_BITS-1:0]     pixel_y_i,
  // output channel
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic [lrpt_pkg::PIX_W-1:0]               pixel_out_o,
  output logic [1:0]                               zone_o
);

  localparam int DW = lrpt_pkg::DIFF_W;
  localparam int AW = lrpt_pkg::ABS_W;
  localparam int CB = lrpt_pkg::COORD_BITS;
  localparam int CW = lrpt_pkg::CENTRE_W;

  // --------------------------------------------------------------------------
  // Configuration registers. The user must make writes arrive only while the pipeline is idle; it is not enforced.
  // --------------------------------------------------------------------------
  logic signed [CW-1:0]               centre_x_q, centre_y_q;
  logic [lrpt_pkg::RADIUS_W-1:0]      inner_q, outer_q;
  logic [lrpt_pkg::GAIN_W-1:0]        gain_r_q, gain_g_q, gain_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      centre_x_q <= '0;
      centre_y_q <= '0;
      inner_q    <= '0;
      outer_q    <= '0;
      gain_r_q   <= lrpt_pkg::GAIN_UNITY;
      gain_g_q   <= lrpt_pkg::GAIN_UNITY;
      gain_b_q   <= lrpt_pkg::GAIN_UNITY;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        lrpt_pkg::REG_CENTRE_X:     centre_x_q <= cfg_data_i;
        lrpt_pkg::REG_CENTRE_Y:     centre_y_q <= cfg_data_i;
        lrpt_pkg::REG_INNER_RADIUS: inner_q    <= cfg_data_i[lrpt_pkg::RADIUS_W-1:0];
        lrpt_pkg::REG_OUTER_RADIUS: outer_q    <= cfg_data_i[lrpt_pkg::RADIUS_W-1:0];
        lrpt_pkg::REG_GAIN_RED:     gain_r_q   <= cfg_data_i[lrpt_pkg::GAIN_W-1:0];
        lrpt_pkg::REG_GAIN_GREEN:   gain_g_q   <= cfg_data_i[lrpt_pkg::GAIN_W-1:0];
        lrpt_pkg::REG_GAIN_BLUE:    gain_b_q   <= cfg_data_i[lrpt_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Flow control. Each stage loads when it is empty or when its successor
  // moves on, so a stall at the output only holds the stages that are full.
  // --------------------------------------------------------------------------
  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  assign rdy5 = !v5_q || !out_stall_i;
  assign rdy4 = !v4_q || rdy5;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;

  assign in_stall_o  = !rdy1;
  assign out_valid_o = v5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
      if (rdy5) v5_q <= v4_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: distance components |x - cx| and |y - cy|, plus the dither parity.
  // --------------------------------------------------------------------------
  logic signed [DW-1:0] dx_d, dy_d;
  logic [AW-1:0]        adx_d, ady_d;

  assign dx_d = $signed({{(DW-CB){1'b0}}, pixel_x_i})
              - $signed({{(DW-CW){centre_x_q[CW-1]}}, centre_x_q});
  assign dy_d = $signed({{(DW-CB){1'b0}}, pixel_y_i})
              - $signed({{(DW-CW){centre_y_q[CW-1]}}, centre_y_q});
  // The magnitudes stay below half the signed range, so the top bit drops.
  assign adx_d = dx_d[DW-1] ? AW'(-dx_d) : AW'(dx_d);
  assign ady_d = dy_d[DW-1] ? AW'(-dy_d) : AW'(dy_d);

  logic [lrpt_pkg::PIX_W-1:0] pix1_q;
  logic [AW-1:0]              adx1_q, ady1_q;
  logic                       odd1_q;

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      pix1_q <= pixel_in_i;
      adx1_q <= adx_d;
      ady1_q <= ady_d;
      odd1_q <= pixel_x_i[0] ^ pixel_y_i[0];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: squares of the components and of both radii.
  // --------------------------------------------------------------------------
  logic [lrpt_pkg::PIX_W-1:0] pix2_q;
  logic [lrpt_pkg::SQ_W-1:0]  sqx2_q, sqy2_q;
  logic [lrpt_pkg::RSQ_W-1:0] rin2_q, rout2_q;
  logic                       odd2_q;

  always_ff @(posedge clk_i) begin
    if (rdy2) begin
      pix2_q  <= pix1_q;
      odd2_q  <= odd1_q;
      sqx2_q  <= lrpt_pkg::SQ_W'(adx1_q) * lrpt_pkg::SQ_W'(adx1_q);
      sqy2_q  <= lrpt_pkg::SQ_W'(ady1_q) * lrpt_pkg::SQ_W'(ady1_q);
      rin2_q  <= lrpt_pkg::RSQ_W'(inner_q) * lrpt_pkg::RSQ_W'(inner_q);
      rout2_q <= lrpt_pkg::RSQ_W'(outer_q) * lrpt_pkg::RSQ_W'(outer_q);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: d = dx^2 + floor(5*dy^2/4), and the channel products.
  // --------------------------------------------------------------------------
  logic [lrpt_pkg::SQ5_W-1:0]  sqy5_d;
  logic [lrpt_pkg::DIST_W-1:0] dist_d;
  lrpt_pkg::prod_t             prod_d;

  assign sqy5_d = lrpt_pkg::SQ5_W'(sqy2_q) + (lrpt_pkg::SQ5_W'(sqy2_q) << 2);
  assign dist_d = lrpt_pkg::DIST_W'(sqx2_q) + lrpt_pkg::DIST_W'(sqy5_d >> 2);

  lrpt_chan_prod u_chan_prod (
    .pixel_i      (pix2_q),
    .gain_red_i   (gain_r_q),
    .gain_green_i (gain_g_q),
    .gain_blue_i  (gain_b_q),
    .prod_o       (prod_d)
  );

  logic [lrpt_pkg::PIX_W-1:0]  pix3_q;
  logic [lrpt_pkg::DIST_W-1:0] dist3_q;
  logic [lrpt_pkg::RSQ_W-1:0]  rin3_q, rout3_q;
  logic                        odd3_q;
  lrpt_pkg::prod_t             prod3_q;

  always_ff @(posedge clk_i) begin
    if (rdy3) begin
      pix3_q  <= pix2_q;
      odd3_q  <= odd2_q;
      dist3_q <= dist_d;
      rin3_q  <= rin2_q;
      rout3_q <= rout2_q;
      prod3_q <= prod_d;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: zone decision and the divide by 20 of the warm numerators.
  // The reciprocal 3277/65536 is exact under floor for numerators below 8192.
  // --------------------------------------------------------------------------
  lrpt_pkg::zone_e               zone_d;
  logic [lrpt_pkg::RPROD_W-1:0]  rq_g_d, rq_b_d;

  always_comb begin
    priority if (dist3_q < lrpt_pkg::DIST_W'(rin3_q)) begin
      zone_d = lrpt_pkg::ZONE_WARM;
    end else if (dist3_q < lrpt_pkg::DIST_W'(rout3_q) && odd3_q) begin
      zone_d = lrpt_pkg::ZONE_DITHER;
    end else begin
      zone_d = lrpt_pkg::ZONE_GAIN;
    end
  end

  assign rq_g_d = (lrpt_pkg::RPROD_W'(prod3_q.warm_g) * lrpt_pkg::RPROD_W'(lrpt_pkg::RECIP20))
                  >> lrpt_pkg::RECIP_SHIFT;
  assign rq_b_d = (lrpt_pkg::RPROD_W'(prod3_q.warm_b) * lrpt_pkg::RPROD_W'(lrpt_pkg::RECIP20))
                  >> lrpt_pkg::RECIP_SHIFT;

  logic [lrpt_pkg::PIX_W-1:0]   pix4_q;
  lrpt_pkg::zone_e              zone4_q;
  logic [lrpt_pkg::QUOT_W-1:0]  warm_g4_q, warm_b4_q;
  logic [lrpt_pkg::GAIN_W-1:0]  gain_r4_q, gain_g4_q, gain_b4_q;

  always_ff @(posedge clk_i) begin
    if (rdy4) begin
      pix4_q    <= pix3_q;
      zone4_q   <= zone_d;
      warm_g4_q <= rq_g_d[lrpt_pkg::QUOT_W-1:0];
      warm_b4_q <= rq_b_d[lrpt_pkg::QUOT_W-1:0];
      // Q2.8 gains: drop the eight fraction bits of each product.
      gain_r4_q <= prod3_q.gain_r[lrpt_pkg::GPROD_W-1:8];
      gain_g4_q <= prod3_q.gain_g[lrpt_pkg::GPROD_W-1:8];
      gain_b4_q <= prod3_q.gain_b[lrpt_pkg::GPROD_W-1:8];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: per-zone selection with saturation into the output register.
  // --------------------------------------------------------------------------
  logic [lrpt_pkg::PIX_W-1:0] pix_out_d;

  always_comb begin
    unique case (zone4_q)
      lrpt_pkg::ZONE_WARM: begin
        pix_out_d = {pix4_q[23:16],
                     lrpt_pkg::sat8(lrpt_pkg::GAIN_W'(warm_g4_q)),
                     lrpt_pkg::sat8(lrpt_pkg::GAIN_W'(warm_b4_q))};
      end
      lrpt_pkg::ZONE_DITHER: begin
        pix_out_d = pix4_q;
      end
      default: begin
        pix_out_d = {lrpt_pkg::sat8(gain_r4_q),
                     lrpt_pkg::sat8(gain_g4_q),
                     lrpt_pkg::sat8(gain_b4_q)};
      end
    endcase
  end

  logic [lrpt_pkg::PIX_W-1:0] pix5_q;
  lrpt_pkg::zone_e            zone5_q;

  always_ff @(posedge clk_i) begin
    if (rdy5) begin
      pix5_q  <= pix_out_d;
      zone5_q <= zone4_q;
    end
  end

  assign pixel_out_o = pix5_q;
  assign zone_o      = zone5_q;

endmodule
`default_nettype wire
